@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the branch predictor checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define LHBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define LHBP_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/lhbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lhbp_pkg
// Widths, row layout, beat layouts and controller states of the local
// history branch predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lhbp_pkg;

   localparam int MAX_ENTRIES     = 64;
   localparam int HISTORY_BITS    = 3;
   localparam int MISS_COUNT_BITS = 16;

   localparam int ADDR_W = 16;
   localparam int CFG_W  = 7;
   localparam int CTR_W  = 2;
   localparam int ENT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int DIV_W  = $clog2(MAX_ENTRIES + 1);

   localparam int CTR_PER_ENTRY = 1 << HISTORY_BITS;

   // modulo unit: address bits consumed per cycle
   localparam int MOD_STEP   = 8;
   localparam int MOD_CYCLES = (ADDR_W + MOD_STEP - 1) / MOD_STEP;
   localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

   typedef logic [CTR_W-1:0] ctr_type;

   typedef struct packed {
      logic [MISS_COUNT_BITS-1:0]    miss;
      logic [HISTORY_BITS-1:0]       hist;
      ctr_type [CTR_PER_ENTRY-1:0]   ctrs;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   localparam int REQ_FIELDS_W = ADDR_W + 1;
   localparam int REQ_W        = ((REQ_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic [REQ_W-REQ_FIELDS_W-1:0] pad;
      logic                          taken;
      logic [ADDR_W-1:0]             instr_address;
   } req_type;

   localparam int RSP_FIELDS_W = ENT_W + HISTORY_BITS + CTR_W + 2 + MISS_COUNT_BITS;
   localparam int RSP_W        = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic [RSP_W-RSP_FIELDS_W-1:0] pad;
      logic [MISS_COUNT_BITS-1:0]    miss_total;
      logic                          mispredicted;
      logic                          predicted_taken;
      ctr_type                       counter_before;
      logic [HISTORY_BITS-1:0]       history_used;
      logic [ENT_W-1:0]              entry_index;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPD
   } state_type;

endpackage

@@ sv/local_history_branch_predictor.sv @@
// Two-level local branch predictor. Each request beat is one resolved
// instruction; each response beat reports the entry used, its history, the
// counter that made the prediction, the prediction, whether it missed and the
// entry's saturating miss count after the update. A beat passes through the
// modulo unit (8 address bits per cycle, then the row read of the single
// entry RAM) and then the row is updated and written back. A new request is
// taken in the write-back cycle of the last one at the earliest, so the block
// works on one request at a time; the response register holds the previous
// response while the next request is worked out, and the write-back waits
// while that response is still unaccepted. Per-entry valid bits make the tables read as zero after
// reset, so there is no clearing pass.
// ----------------------------------------------------------------------------
// local_history_branch_predictor
// Top level: controller, valid bits, row update and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_history_branch_predictor import lhbp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,   // entries_in_use
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // instr_address, taken
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // entry_index, history_used,
                                         // counter_before, predicted_taken,
                                         // mispredicted, miss_total
);

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     cfg_ff;
   logic                 taken_ff;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [ENT_W-1:0]     ent_ff;
   logic                 rd_valid_ff;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type              rsp_data_ff;

   req_type              req;
   logic [DIV_W-1:0]     divisor;
   logic                 accept;
   logic                 out_free;
   logic                 mod_done;
   logic [ENT_W-1:0]     mod_rem;
   logic                 rd_issue;
   logic                 upd_fire;
   logic [ROW_W-1:0]     ram_rd_data;
   row_type              row_cur, row_new;
   ctr_type              ctr;
   logic                 pred, miss;
   rsp_type              rsp_new;

   assign req      = req_type'(req_tdata);
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      if (cfg_ff == '0) begin
         divisor = DIV_W'(1);
      end else if (int'(cfg_ff) > MAX_ENTRIES) begin
         divisor = DIV_W'(MAX_ENTRIES);
      end else begin
         divisor = DIV_W'(cfg_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (mod_done) state_in = ST_UPD;
         end
         ST_UPD: begin
            if (out_free) state_in = req_tvalid ? ST_DIV : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready = 1'b0;
      rd_issue   = 1'b0;
      upd_fire   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_DIV:  rd_issue   = mod_done;
         ST_UPD: begin
            upd_fire   = out_free;
            req_tready = out_free;
         end
         default: ;
      endcase
   end

   lhbp_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req.instr_address),
      .divisor   (divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   lhbp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_ENTRIES)
   ) u_rows (
      .clock   (clock),
      .wr_en   (upd_fire),
      .wr_addr (ent_ff),
      .wr_data (row_new),
      .rd_en   (rd_issue),
      .rd_addr (mod_rem),
      .rd_data (ram_rd_data)
   );

   // row update
   always_comb begin
      row_cur = rd_valid_ff ? row_type'(ram_rd_data) : '0;
      ctr     = row_cur.ctrs[row_cur.hist];
      pred    = ctr[1];
      miss    = pred != taken_ff;
      row_new = row_cur;
      if (miss && !(&row_cur.miss)) begin
         row_new.miss = row_cur.miss + MISS_COUNT_BITS'(1);
      end
      if (taken_ff) begin
         if (ctr != '1) row_new.ctrs[row_cur.hist] = ctr + CTR_W'(1);
      end else begin
         if (ctr != '0) row_new.ctrs[row_cur.hist] = ctr - CTR_W'(1);
      end
      row_new.hist = HISTORY_BITS'({row_cur.hist, taken_ff});

      rsp_new                 = '0;
      rsp_new.entry_index     = ent_ff;
      rsp_new.history_used    = row_cur.hist;
      rsp_new.counter_before  = ctr;
      rsp_new.predicted_taken = pred;
      rsp_new.mispredicted    = miss;
      rsp_new.miss_total      = row_new.miss;
   end

   always_comb begin
      valid_in = valid_ff;
      if (upd_fire) valid_in[ent_ff] = 1'b1;
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (upd_fire) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_ff        <= CFG_W'(1);
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) cfg_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) taken_ff <= req.taken;
      if (rd_issue) begin
         ent_ff      <= mod_rem;
         rd_valid_ff <= valid_ff[mod_rem];
      end
      if (upd_fire) rsp_data_ff <= rsp_new;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sv/lhbp_mod_unit.sv @@
// ----------------------------------------------------------------------------
// lhbp_mod_unit
// Iterative restoring remainder: address modulo entry count, several
// address bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lhbp_mod_unit import lhbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic              done,
   output logic [ENT_W-1:0]  remainder
);

   localparam int CMP_W = ENT_W + 2;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    shreg_ff, shreg_in;
   logic [ENT_W-1:0]     rem_ff, rem_in;
   logic [ENT_W-1:0]     step_rem;

   always_comb begin
      logic [ENT_W:0] t;
      step_rem = rem_ff;
      for (int i = 0; i < MOD_STEP; i++) begin
         t = {step_rem, shreg_ff[ADDR_W-1-i]};
         if (CMP_W'(t) >= CMP_W'(divisor)) begin
            step_rem = ENT_W'(CMP_W'(t) - CMP_W'(divisor));
         end else begin
            step_rem = ENT_W'(t);
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shreg_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = step_rem;
         shreg_in = shreg_ff << MOD_STEP;
         cnt_in   = cnt_ff + MOD_CNT_W'(1);
         if (cnt_ff == MOD_CNT_W'(MOD_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/lhbp_ram.sv @@
// ----------------------------------------------------------------------------
// lhbp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lhbp_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lhbp_checker.sv @@
// ----------------------------------------------------------------------------
// lhbp_checker
// Port-level checks on the branch predictor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lhbp_port_checks import lhbp_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   rsp_type rsp;
   logic    rsp_stall;
   logic    req_beat;
   logic    pred_ok;
   logic    miss_ok;

   assign rsp       = rsp_type'(rsp_tdata);
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_beat  = req_tvalid && req_tready;
   assign pred_ok   = rsp.predicted_taken == rsp.counter_before[1];
   assign miss_ok   = !rsp.mispredicted || (rsp.miss_total != '0);

   `LHBP_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_tvalid, "response valid after reset")
   `LHBP_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "beat changed")
   `LHBP_ASSERT(a_pred_ctr, clock, reset, rsp_tvalid |-> pred_ok, "prediction disagrees with counter")
   `LHBP_ASSERT(a_miss_count, clock, reset, rsp_tvalid |-> miss_ok, "miss with zero miss count")
   `LHBP_ASSERT(a_busy_after_accept, clock, reset, req_beat |=> !req_tready, "request taken while busy")

endmodule

bind local_history_branch_predictor lhbp_port_checks u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/lhbp_checker.sv @@
// ----------------------------------------------------------------------------
// lhbp_checker
// Watches the request, response and register ports of the local history
// branch predictor, keeps its own history, counter and miss tables, works out
// the response beat that each accepted request must produce and compares the
// responses in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lhbp_checker import lhbp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             end_of_test,
   output logic [31:0]      fail_count,
   output logic [31:0]      outstanding
);

   localparam int PRINT_CAP = 100;

   logic [HISTORY_BITS-1:0]    hist_mem [MAX_ENTRIES];
   ctr_type                    ctr_mem  [MAX_ENTRIES*CTR_PER_ENTRY];
   logic [MISS_COUNT_BITS-1:0] miss_mem [MAX_ENTRIES];
   logic [CFG_W-1:0]           entries_cfg;

   rsp_type branch_reports_q[$];
   req_type req_beat;
   rsp_type rsp_beat;
   rsp_type want;
   rsp_type fresh;
   bit      end_checked;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      end_checked = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                  input logic [31:0] got_v);
      if (fail_count < PRINT_CAP)
         $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
      fail_count = fail_count + 1;
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) report_mismatch(name, want_v, got_v);
   endtask

   // one resolved branch: predict from the entry, then train it
   task automatic resolve_branch(input logic [ADDR_W-1:0] addr, input logic taken,
                                 output rsp_type rpt);
      int unsigned n;
      int unsigned ent;
      int unsigned slot;
      ctr_type     c;
      logic        pred;
      n = 32'(entries_cfg);
      if (n == 0) n = 1;
      if (n > MAX_ENTRIES) n = MAX_ENTRIES;
      ent  = addr % n;
      slot = ent * CTR_PER_ENTRY + hist_mem[ent];
      c    = ctr_mem[slot];
      pred = c[1];
      rpt = '0;
      rpt.entry_index     = ent[ENT_W-1:0];
      rpt.history_used    = hist_mem[ent];
      rpt.counter_before  = c;
      rpt.predicted_taken = pred;
      rpt.mispredicted    = (pred != taken);
      if (pred != taken && miss_mem[ent] != '1)
         miss_mem[ent] = miss_mem[ent] + 1'b1;
      if (taken && c != 2'd3)
         ctr_mem[slot] = c + 2'd1;
      else if (!taken && c != 2'd0)
         ctr_mem[slot] = c - 2'd1;
      hist_mem[ent] = {hist_mem[ent][HISTORY_BITS-2:0], taken};
      rpt.miss_total = miss_mem[ent];
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            hist_mem[i] = '0;
            miss_mem[i] = '0;
         end
         for (int i = 0; i < MAX_ENTRIES*CTR_PER_ENTRY; i++) ctr_mem[i] = '0;
         entries_cfg = 7'd1;
         branch_reports_q.delete();
      end else begin
         if (csr_we) entries_cfg = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            rsp_beat = rsp_tdata;
            if (branch_reports_q.size() == 0) begin
               report_mismatch("unexpected response beat, entry", 0,
                               32'(rsp_beat.entry_index));
            end else begin
               want = branch_reports_q.pop_front();
               check_field("entry_index", 32'(want.entry_index),
                           32'(rsp_beat.entry_index));
               check_field("history_used", 32'(want.history_used),
                           32'(rsp_beat.history_used));
               check_field("counter_before", 32'(want.counter_before),
                           32'(rsp_beat.counter_before));
               check_field("predicted_taken", 32'(want.predicted_taken),
                           32'(rsp_beat.predicted_taken));
               check_field("mispredicted", 32'(want.mispredicted),
                           32'(rsp_beat.mispredicted));
               check_field("miss_total", 32'(want.miss_total),
                           32'(rsp_beat.miss_total));
            end
         end
         if (req_tvalid && req_tready) begin
            req_beat = req_tdata;
            resolve_branch(req_beat.instr_address, req_beat.taken, fresh);
            branch_reports_q.insert(branch_reports_q.size(), fresh);
         end
         if (end_of_test && !end_checked) begin
            end_checked = 1;
            while (branch_reports_q.size() > 0) begin
               want = branch_reports_q.pop_front();
               report_mismatch("no response beat for entry", 32'(want.entry_index), 0);
            end
         end
      end
      outstanding <= branch_reports_q.size();
   end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the local history branch predictor. A short
// directed part hits address and counter extremes and the entry-count corner
// values, then randomized phases of loop-like and random branches run under
// several entry counts with bursty stalls on both sides and one long response
// hold-off, and a final gap-free phase walks one entry through every history
// pattern with both outcomes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import lhbp_pkg::*;

   localparam int               CYCLE_LIMIT     = 4_000_000;
   localparam int               LONG_HOLD       = 64;
   localparam int               PHASE_BEATS     = 100;
   localparam int               PATTERN_PERIODS = 8;
   localparam logic [5:0]       PATTERN_ENTRY   = 6'd21;
   // every 4-bit window once: each 3-bit history sees both outcomes in turn
   localparam logic [15:0]      DEBRUIJN        = 16'b0000100110101111;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             end_of_test;
   logic [31:0]      fail_count;
   logic [31:0]      outstanding;

   bit gaps_on;
   int hold_requests;
   int beats_sent;
   int directed_beats;
   int settings_used;
   int cycle_count;

   local_history_branch_predictor u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lhbp_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .end_of_test (end_of_test),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
   end

   // response side: random stalls, plus the long hold-off when asked
   initial begin : rsp_side
      int holds_done;
      holds_done = 0;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_beat(input logic [ADDR_W-1:0] addr, input logic taken);
      req_type beat;
      beat = '0;
      beat.instr_address = addr;
      beat.taken = taken;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_entries(input logic [CFG_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] value, input bit gaps, input bit hold);
      logic [ADDR_W-1:0] pool_addr [8];
      int                pool_kind [8];
      int                pool_len  [8];
      int                pool_cnt  [8];
      logic [ADDR_W-1:0] addr;
      logic              taken;
      int                k;
      set_entries(value);
      gaps_on <= gaps;
      if (hold) hold_requests <= hold_requests + 1;
      for (int i = 0; i < 8; i++) begin
         pool_addr[i] = ADDR_W'($urandom);
         pool_kind[i] = $urandom_range(0, 3);
         pool_len[i]  = $urandom_range(2, 7);
         pool_cnt[i]  = 0;
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
         if ($urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, 7);
            addr = pool_addr[k];
            case (pool_kind[k])
               0: taken = 1'b1;
               1: taken = 1'b0;
               2: begin
                  // loop branch: taken len-1 times, then falls through
                  taken = (pool_cnt[k] % pool_len[k]) != pool_len[k] - 1;
                  pool_cnt[k]++;
               end
               default: taken = 1'($urandom_range(0, 1));
            endcase
         end else begin
            addr  = ADDR_W'($urandom);
            taken = 1'($urandom_range(0, 1));
         end
         send_beat(addr, taken);
      end
   endtask

   initial begin : stimulus
      logic [9:0] hi;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      end_of_test    = 1'b0;
      gaps_on        = 1'b0;
      hold_requests  = 0;
      beats_sent     = 0;
      settings_used  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one entry after reset: train up to strong taken, then down past zero
      send_beat(16'h0000, 1'b0);
      send_beat(16'hFFFF, 1'b1);
      repeat (7) send_beat(ADDR_W'($urandom), 1'b1);
      repeat (5) send_beat(ADDR_W'($urandom), 1'b0);
      set_entries(7'd0);
      send_beat(16'hABCD, 1'b1);
      send_beat(16'h5432, 1'b0);
      set_entries(7'd127);
      send_beat(16'hFFFF, 1'b1);
      send_beat(16'h0040, 1'b0);
      send_beat(16'h007F, 1'b1);
      set_entries(7'd64);
      send_beat(16'hFFC0, 1'b1);
      send_beat(16'h003F, 1'b0);
      set_entries(7'd63);
      send_beat(16'hFFFF, 1'b1);
      send_beat(16'h003F, 1'b0);
      directed_beats = beats_sent;

      run_phase(7'd2, 1'b1, 1'b0);
      run_phase(7'd127, 1'b1, 1'b0);
      run_phase(7'($urandom_range(65, 126)), 1'b1, 1'b0);
      run_phase(7'd1, 1'b0, 1'b1);
      run_phase(7'd64, 1'b1, 1'b0);
      run_phase(7'd0, 1'b1, 1'b0);
      run_phase(7'($urandom_range(3, 63)), 1'b1, 1'b0);
      run_phase(7'd63, 1'b1, 1'b0);

      // every beat lands on one entry and walks its history through each
      // 3-bit pattern with both outcomes, no idling on either side
      gaps_on <= 1'b0;
      set_entries(7'd64);
      for (int p = 0; p < PATTERN_PERIODS; p++) begin
         for (int b = 0; b < 16; b++) begin
            hi = 10'($urandom_range(0, 1023));
            send_beat({hi, PATTERN_ENTRY}, DEBRUIJN[15-b]);
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      $display("%0d request beats (%0d directed) over %0d entry-count writes, 0 to 127",
               beats_sent, directed_beats, settings_used);
      $display("entry %0d cycled through all histories back to back; %0d mismatches",
               PATTERN_ENTRY, fail_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
